[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and codes for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_RUN     = 2'd2;
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1_START,
        ST_P1_READ,
        ST_P1_STEP,
        ST_P2_START,
        ST_P2_FETCH,
        ST_P2_CHECK,
        ST_P2_READ,
        ST_P2_STEP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic p1_init;
        logic p1_start;
        logic p1_read;
        logic p1_step;
        logic p2_init;
        logic p2_fetch;
        logic p2_check;
        logic p2_read;
        logic p2_step;
    } cmd_t;

    typedef struct packed {
        logic start_done;
        logic start_visited;
        logic has_next;
        logic walk_empty;
        logic walk_one;
        logic finish_empty;
        logic fetched_visited;
        logic out_busy;
    } status_t;

endpackage

[rtl/strongly_connected_components.sv]
// ----------------------------------------------------------------------------
// strongly_connected_components
// Kosaraju component search over a stored directed graph.
//
//   channel   direction  handshake
//   in        input      in_valid / in_stall
//   out       output     out_valid / out_stall
//   cfg       input      cfg_valid / cfg_ready
//
// Edge updates are accepted back to back while idle. A search walks the
// graph through the one-row edge store read and the shared walk stack;
// input stalls meanwhile. Reset clears the edge store at once.
// Output stalls freeze the second pass.
// ----------------------------------------------------------------------------
module strongly_connected_components #(
    parameter int MAX_VERTICES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [4:0] source_vertex,
    input  logic [4:0] target_vertex,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] vertex_id,
    output logic [4:0] component_index,
    output logic       component_end,
    output logic       last,
    output logic [5:0] component_total,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);

`include "assert_macros.svh"

    localparam int LIM = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;

    logic [5:0]       vertex_count_reg;
    logic [5:0]       vertex_limit;
    logic             idle;
    logic             accept;
    scc_pkg::cmd_t    cmd;
    scc_pkg::status_t status;

    assign in_stall  = !idle;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    assign vertex_limit = (vertex_count_reg == 6'd0) ? 6'd1 :
                          (32'(vertex_count_reg) > LIM) ? 6'(LIM) : vertex_count_reg;

    scc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_start (accept && action == scc_pkg::ACT_RUN),
        .status    (status),
        .cmd       (cmd),
        .idle      (idle)
    );

    scc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .edge_write      (accept && (action == scc_pkg::ACT_ADD
                                     || action == scc_pkg::ACT_REMOVE)),
        .edge_set        (action == scc_pkg::ACT_ADD),
        .source_vertex   (source_vertex),
        .target_vertex   (target_vertex),
        .vertex_limit    (vertex_limit),
        .cmd             (cmd),
        .status          (status),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .vertex_id       (vertex_id),
        .component_index (component_index),
        .component_end   (component_end),
        .last            (last),
        .component_total (component_total)
    );

    `ASSERT_IMPL(a_last_ends, out_valid && last, component_end, "last beat must end a component")
    `ASSERT_NEXT(a_run_busy, accept && action == scc_pkg::ACT_RUN, in_stall, "run must stall input")
    `ASSERT_IMPL(a_total_zero, out_valid && !last, component_total == 6'd0, "total only on last")

endmodule

[rtl/scc_datapath.sv]
// ----------------------------------------------------------------------------
// scc_datapath
// Edge store, visited mask, stacks and result register of the search.
// ----------------------------------------------------------------------------
module scc_datapath #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                edge_write,
    input  logic                edge_set,
    input  logic [4:0]          source_vertex,
    input  logic [4:0]          target_vertex,
    input  logic [5:0]          vertex_limit,
    input  scc_pkg::cmd_t       cmd,
    output scc_pkg::status_t    status,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [4:0]          vertex_id,
    output logic [4:0]          component_index,
    output logic                component_end,
    output logic                last,
    output logic [5:0]          component_total
);

    localparam int NV = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int VW = (NV > 1) ? $clog2(NV) : 1;

    logic [NV-1:0] fwd_reg [NV];
    logic [NV-1:0] rev_reg [NV];
    logic [NV-1:0] visited_reg;
    logic [4:0]    finish_mem [NV];
    logic [4:0]    walk_mem [NV];
    logic [VW:0]   finish_depth_reg;
    logic [VW:0]   walk_depth_reg;
    logic [VW:0]   scan_reg;
    logic [4:0]    top_reg;
    logic [4:0]    fetch_reg;
    logic [5:0]    comp_reg;
    logic [NV-1:0] row_reg;
    logic [NV-1:0] live;
    logic [NV-1:0] cand;
    logic [4:0]    low_idx;
    logic          pend_valid_reg;
    logic [4:0]    pend_vertex_reg;
    logic [4:0]    pend_comp_reg;
    logic          out_valid_reg;
    logic [4:0]    out_vertex_reg;
    logic [4:0]    out_comp_reg;
    logic          out_end_reg;
    logic          out_last_reg;
    logic [5:0]    out_total_reg;
    logic          push;
    logic          close_comp;
    logic          close_all;
    logic          out_free;

    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            live[i] = (6'(i) < vertex_limit);
        end
    end

    assign cand = row_reg & live & ~visited_reg;

    always_comb
    begin
        low_idx = '0;
        for (int i = NV - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                low_idx = 5'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV; i++)
            begin
                fwd_reg[i] <= '0;
                rev_reg[i] <= '0;
            end
        end
        else if (edge_write && 32'(source_vertex) < NV && 32'(target_vertex) < NV)
        begin
            fwd_reg[source_vertex[VW-1:0]][target_vertex[VW-1:0]] <= edge_set;
            rev_reg[target_vertex[VW-1:0]][source_vertex[VW-1:0]] <= edge_set;
        end
    end

    // A newly visited vertex pushes onto the walk stack; in the second pass
    // the pending slot holds it until it is known whether it closes its component.
    // The last component closes once every live vertex has been visited.
    assign push = (cmd.p1_start && !status.start_visited)
                  || (cmd.p2_check && !status.fetched_visited)
                  || ((cmd.p1_step || cmd.p2_step) && status.has_next);
    assign close_comp = cmd.p2_step && !status.has_next && (walk_depth_reg == (VW+1)'(1));
    assign close_all = close_comp && ((visited_reg & live) == live);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.p1_read || cmd.p2_read)
        begin
            row_reg <= cmd.p1_read ? fwd_reg[top_reg[VW-1:0]] : rev_reg[top_reg[VW-1:0]];
        end
        if (cmd.p1_start)
        begin
            top_reg <= 5'(scan_reg);
            if (!status.start_visited)
            begin
                walk_mem[walk_depth_reg[VW-1:0]] <= 5'(scan_reg);
            end
        end
        else if (cmd.p2_check && !status.fetched_visited)
        begin
            top_reg <= fetch_reg;
            walk_mem[walk_depth_reg[VW-1:0]] <= fetch_reg;
        end
        else if ((cmd.p1_step || cmd.p2_step) && status.has_next)
        begin
            top_reg <= low_idx;
            walk_mem[walk_depth_reg[VW-1:0]] <= low_idx;
        end
        else if ((cmd.p1_step || cmd.p2_step) && walk_depth_reg > (VW+1)'(1))
        begin
            top_reg <= walk_mem[VW'(walk_depth_reg - (VW+1)'(2))];
        end
        if (cmd.p1_step && !status.has_next)
        begin
            finish_mem[finish_depth_reg[VW-1:0]] <= top_reg;
        end
        if (cmd.p2_fetch)
        begin
            fetch_reg <= finish_mem[VW'(finish_depth_reg - (VW+1)'(1))];
        end
        if (cmd.p2_check && !status.fetched_visited)
        begin
            pend_vertex_reg <= fetch_reg;
            pend_comp_reg <= comp_reg[4:0];
        end
        else if (cmd.p2_step && status.has_next)
        begin
            pend_vertex_reg <= low_idx;
            pend_comp_reg <= comp_reg[4:0];
        end
        if (out_free && pend_valid_reg
            && ((cmd.p2_step && status.has_next) || close_comp))
        begin
            out_vertex_reg <= pend_vertex_reg;
            out_comp_reg <= pend_comp_reg;
            out_end_reg <= close_comp;
            out_last_reg <= close_all;
            out_total_reg <= close_all ? comp_reg + 6'd1 : 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            finish_depth_reg <= '0;
            walk_depth_reg <= '0;
            scan_reg <= '0;
            comp_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.p1_init || cmd.p2_init)
            begin
                visited_reg <= '0;
                walk_depth_reg <= '0;
                scan_reg <= '0;
                comp_reg <= '0;
                if (cmd.p1_init)
                begin
                    finish_depth_reg <= '0;
                end
            end
            if (cmd.p1_start)
            begin
                scan_reg <= scan_reg + (VW+1)'(1);
                if (!status.start_visited)
                begin
                    visited_reg[scan_reg[VW-1:0]] <= 1'b1;
                end
            end
            if (push && !cmd.p1_start)
            begin
                visited_reg[cmd.p2_check ? fetch_reg[VW-1:0] : low_idx[VW-1:0]] <= 1'b1;
            end
            if (push)
            begin
                walk_depth_reg <= walk_depth_reg + (VW+1)'(1);
            end
            else if ((cmd.p1_step || cmd.p2_step) && !status.has_next)
            begin
                walk_depth_reg <= walk_depth_reg - (VW+1)'(1);
            end
            if (cmd.p1_step && !status.has_next)
            begin
                finish_depth_reg <= finish_depth_reg + (VW+1)'(1);
            end
            if (cmd.p2_fetch)
            begin
                finish_depth_reg <= finish_depth_reg - (VW+1)'(1);
            end
            if (close_comp)
            begin
                comp_reg <= comp_reg + 6'd1;
            end
            if (out_free && pend_valid_reg
                && ((cmd.p2_step && status.has_next) || close_comp))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((cmd.p2_check && !status.fetched_visited) || (cmd.p2_step && status.has_next))
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (close_comp)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assign status.start_done      = (scan_reg >= vertex_limit[VW:0]) || (6'(scan_reg) >= vertex_limit);
    assign status.start_visited   = visited_reg[scan_reg[VW-1:0]];
    assign status.has_next        = |cand;
    assign status.walk_empty      = (walk_depth_reg == '0);
    assign status.walk_one        = (walk_depth_reg == (VW+1)'(1));
    assign status.finish_empty    = (finish_depth_reg == '0);
    assign status.fetched_visited = visited_reg[fetch_reg[VW-1:0]];
    assign status.out_busy        = out_valid_reg && out_stall;

    assign out_valid       = out_valid_reg;
    assign vertex_id       = out_vertex_reg;
    assign component_index = out_comp_reg;
    assign component_end   = out_end_reg;
    assign last            = out_last_reg;
    assign component_total = out_total_reg;

endmodule

[rtl/scc_controller.sv]
// ----------------------------------------------------------------------------
// scc_controller
// Sequences the two depth-first passes of a component search.
// ----------------------------------------------------------------------------
module scc_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                run_start,
    input  scc_pkg::status_t    status,
    output scc_pkg::cmd_t       cmd,
    output logic                idle
);

    scc_pkg::state_t state_reg;
    scc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scc_pkg::ST_IDLE:
            begin
                if (run_start)
                begin
                    state_next = scc_pkg::ST_P1_START;
                end
            end
            scc_pkg::ST_P1_START:
            begin
                if (status.start_done)
                begin
                    state_next = scc_pkg::ST_P2_START;
                end
                else if (!status.start_visited)
                begin
                    state_next = scc_pkg::ST_P1_READ;
                end
            end
            scc_pkg::ST_P1_READ:
            begin
                state_next = scc_pkg::ST_P1_STEP;
            end
            scc_pkg::ST_P1_STEP:
            begin
                if (status.has_next)
                begin
                    state_next = scc_pkg::ST_P1_READ;
                end
                else
                begin
                    state_next = scc_pkg::ST_P1_STEP;
                end
            end
            scc_pkg::ST_P2_START:
            begin
                state_next = scc_pkg::ST_P2_FETCH;
            end
            scc_pkg::ST_P2_FETCH:
            begin
                state_next = scc_pkg::ST_P2_CHECK;
            end
            scc_pkg::ST_P2_CHECK:
            begin
                if (status.fetched_visited)
                begin
                    state_next = status.finish_empty ? scc_pkg::ST_EMIT
                                                     : scc_pkg::ST_P2_FETCH;
                end
                else
                begin
                    state_next = scc_pkg::ST_P2_READ;
                end
            end
            scc_pkg::ST_P2_READ:
            begin
                state_next = scc_pkg::ST_P2_STEP;
            end
            scc_pkg::ST_P2_STEP:
            begin
                if (status.out_busy)
                begin
                    state_next = scc_pkg::ST_P2_STEP;
                end
                else if (status.has_next)
                begin
                    state_next = scc_pkg::ST_P2_READ;
                end
                else
                begin
                    state_next = scc_pkg::ST_P2_STEP;
                end
            end
            scc_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = scc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scc_pkg::ST_IDLE;
            end
        endcase
        // A pop that empties the walk stack ends the tree or the pass.
        if (state_reg == scc_pkg::ST_P1_STEP && !status.has_next)
        begin
            state_next = (status.walk_empty || status.walk_one) ? scc_pkg::ST_P1_START
                                                                : scc_pkg::ST_P1_READ;
        end
        if (state_reg == scc_pkg::ST_P2_STEP && !status.out_busy && !status.has_next)
        begin
            if (status.walk_one)
            begin
                state_next = status.finish_empty ? scc_pkg::ST_EMIT
                                                 : scc_pkg::ST_P2_FETCH;
            end
            else
            begin
                state_next = scc_pkg::ST_P2_READ;
            end
        end
        if (state_reg == scc_pkg::ST_P2_CHECK && status.fetched_visited
            && status.finish_empty)
        begin
            state_next = scc_pkg::ST_EMIT;
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            scc_pkg::ST_IDLE:     cmd.p1_init  = run_start;
            scc_pkg::ST_P1_START: cmd.p1_start = !status.start_done;
            scc_pkg::ST_P1_READ:  cmd.p1_read  = 1'b1;
            scc_pkg::ST_P1_STEP:  cmd.p1_step  = 1'b1;
            scc_pkg::ST_P2_START: cmd.p2_init  = 1'b1;
            scc_pkg::ST_P2_FETCH: cmd.p2_fetch = 1'b1;
            scc_pkg::ST_P2_CHECK: cmd.p2_check = 1'b1;
            scc_pkg::ST_P2_READ:  cmd.p2_read  = 1'b1;
            scc_pkg::ST_P2_STEP:  cmd.p2_step  = !status.out_busy;
            scc_pkg::ST_EMIT:     cmd          = '0;
            default:              cmd          = '0;
        endcase
    end

    assign idle = (state_reg == scc_pkg::ST_IDLE);

endmodule
